// ----- rtl/gqlay_pkg.sv -----
// Shared types, constants and the saturation helper of the glyph quad layout block.
package gqlay_pkg;

  // Internal arithmetic width: wide enough for any sum of the block at up to 16 fraction bits.
  localparam int CALC_W = 40;

  typedef logic signed [CALC_W-1:0] calc_t;
  typedef logic signed [23:0]       coord_t;
  typedef logic signed [10:0]       pix_s_t;
  typedef logic        [9:0]        pix_u_t;
  typedef logic        [15:0]       tex_t;
  typedef logic        [20:0]       code_t;

  // Characters that move the pen.
  localparam code_t CODE_TAB   = 21'd9;
  localparam code_t CODE_NL    = 21'd10;
  localparam code_t CODE_VTAB  = 21'd11;
  localparam code_t CODE_SPACE = 21'd32;

  localparam pix_u_t BASE_SIZE_RST = 10'd32;

  typedef enum logic [1:0] {
    REG_BASE_SIZE = 2'd0,
    REG_BOLD      = 2'd1,
    REG_ITALIC    = 2'd2,
    REG_UNDERLINE = 2'd3
  } cfg_reg_e;

  typedef struct packed {
    pix_u_t base_size;
    logic   bold_on;
    logic   italic_on;
    logic   underline_on;
  } cfg_t;

  // One queued job: optional newline bar, optional glyph quads, optional end-of-text bar.
  typedef struct packed {
    logic   bar_a_en;
    coord_t bar_a_x;
    coord_t bar_a_y;
    logic   glyph_en;
    coord_t gx;
    coord_t gy;
    pix_s_t glyph_left;
    pix_s_t glyph_top;
    pix_u_t glyph_width;
    pix_u_t glyph_height;
    calc_t  shear_bot;
    calc_t  shear_top;
    tex_t   tex_u_min;
    tex_t   tex_u_max;
    tex_t   tex_v_min;
    tex_t   tex_v_max;
    logic   bar_b_en;
    coord_t bar_b_x;
    coord_t bar_b_y;
  } job_t;

  localparam calc_t SAT_HI = calc_t'(8388607);
  localparam calc_t SAT_LO = calc_t'(-8388608);

  function automatic coord_t sat24(input calc_t v);
    if (v > SAT_HI) return coord_t'(SAT_HI);
    if (v < SAT_LO) return coord_t'(SAT_LO);
    return coord_t'(v);
  endfunction

endpackage

// ----- rtl/gqlay_if.sv -----
// Channel interfaces: character input, vertex output and configuration write.
interface gqlay_char_if;
  import gqlay_pkg::*;
  logic   valid;
  logic   ready;
  code_t  char_code;
  logic   glyph_found;
  pix_s_t glyph_left;
  pix_s_t glyph_top;
  pix_u_t glyph_width;
  pix_u_t glyph_height;
  pix_s_t glyph_advance;
  tex_t   tex_u_min;
  tex_t   tex_u_max;
  tex_t   tex_v_min;
  tex_t   tex_v_max;
  logic   end_of_text;

  modport source (
    output valid, char_code, glyph_found, glyph_left, glyph_top, glyph_width, glyph_height,
    output glyph_advance, tex_u_min, tex_u_max, tex_v_min, tex_v_max, end_of_text,
    input  ready
  );
  modport sink (
    input  valid, char_code, glyph_found, glyph_left, glyph_top, glyph_width, glyph_height,
    input  glyph_advance, tex_u_min, tex_u_max, tex_v_min, tex_v_max, end_of_text,
    output ready
  );
endinterface

interface gqlay_vert_if;
  import gqlay_pkg::*;
  logic   valid;
  logic   ready;
  logic   vertex_kind;
  coord_t pos_x;
  coord_t pos_y;
  tex_t   tex_u;
  tex_t   tex_v;
  logic   last_vertex;

  modport source (
    output valid, vertex_kind, pos_x, pos_y, tex_u, tex_v, last_vertex,
    input  ready
  );
  modport sink (
    input  valid, vertex_kind, pos_x, pos_y, tex_u, tex_v, last_vertex,
    output ready
  );
endinterface

interface gqlay_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] index;
  logic [9:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ----- rtl/gqlay_front.sv -----
// Front end: takes characters, moves the pen and builds one job word per character.
module gqlay_front #(
  parameter int unsigned COORD_FRAC_BITS = 8
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  gqlay_pkg::cfg_t cfg_i,
  gqlay_char_if.sink      char_i,
  input  logic            full_i,
  output logic            push_o,
  output gqlay_pkg::job_t job_o
);
  import gqlay_pkg::*;

  localparam calc_t SHEAR_MUL = calc_t'(53);
  localparam calc_t SHEAR_RND = calc_t'(128);
  localparam int    SHEAR_SH  = 8;
  localparam coord_t PEN_Y_RST = coord_t'(calc_t'(BASE_SIZE_RST) <<< COORD_FRAC_BITS);

  coord_t pen_x_q, pen_x_d;
  coord_t pen_y_q, pen_y_d;
  coord_t x_mv, y_mv, px_n, py_n;
  calc_t  adv_c, bsz_c, n_bot, n_top;
  logic   accept;

  assign char_i.ready = !full_i;
  assign accept       = char_i.valid && char_i.ready;

  assign adv_c = calc_t'(char_i.glyph_advance) <<< COORD_FRAC_BITS;
  assign bsz_c = calc_t'(cfg_i.base_size) <<< COORD_FRAC_BITS;

  // Special characters move the pen before the quad is placed.
  always_comb begin
    x_mv = pen_x_q;
    y_mv = pen_y_q;
    unique case (char_i.char_code)
      CODE_SPACE: x_mv = sat24(calc_t'(pen_x_q) + adv_c);
      CODE_NL: begin
        y_mv = sat24(calc_t'(pen_y_q) + bsz_c);
        x_mv = '0;
      end
      CODE_TAB:  x_mv = sat24(calc_t'(pen_x_q) + (adv_c <<< 2));
      CODE_VTAB: y_mv = sat24(calc_t'(pen_y_q) + (bsz_c <<< 2));
      default: ;
    endcase
  end

  assign px_n = char_i.glyph_found ? sat24(calc_t'(x_mv) + adv_c) : pen_x_q;
  assign py_n = char_i.glyph_found ? y_mv : pen_y_q;

  // Italic shear, rounded half up: floor((n*53*2^F + 128) / 256).
  assign n_bot = -calc_t'(char_i.glyph_top) - calc_t'(char_i.glyph_height);
  assign n_top = -calc_t'(char_i.glyph_top);

  always_comb begin
    job_o.bar_a_en     = char_i.glyph_found && (char_i.char_code == CODE_NL) &&
                         cfg_i.underline_on;
    job_o.bar_a_x      = pen_x_q;
    job_o.bar_a_y      = pen_y_q;
    job_o.glyph_en     = char_i.glyph_found;
    job_o.gx           = x_mv;
    job_o.gy           = y_mv;
    job_o.glyph_left   = char_i.glyph_left;
    job_o.glyph_top    = char_i.glyph_top;
    job_o.glyph_width  = char_i.glyph_width;
    job_o.glyph_height = char_i.glyph_height;
    job_o.shear_bot    = cfg_i.italic_on ?
                         (((n_bot * SHEAR_MUL) <<< COORD_FRAC_BITS) + SHEAR_RND) >>> SHEAR_SH :
                         calc_t'(0);
    job_o.shear_top    = cfg_i.italic_on ?
                         (((n_top * SHEAR_MUL) <<< COORD_FRAC_BITS) + SHEAR_RND) >>> SHEAR_SH :
                         calc_t'(0);
    job_o.tex_u_min    = char_i.tex_u_min;
    job_o.tex_u_max    = char_i.tex_u_max;
    job_o.tex_v_min    = char_i.tex_v_min;
    job_o.tex_v_max    = char_i.tex_v_max;
    job_o.bar_b_en     = char_i.end_of_text && cfg_i.underline_on;
    job_o.bar_b_x      = px_n;
    job_o.bar_b_y      = py_n;
  end

  assign push_o = accept && (job_o.bar_a_en || job_o.glyph_en || job_o.bar_b_en);

  always_comb begin
    pen_x_d = pen_x_q;
    pen_y_d = pen_y_q;
    if (accept) begin
      pen_x_d = char_i.end_of_text ? coord_t'(0) : px_n;
      pen_y_d = char_i.end_of_text ? sat24(bsz_c) : py_n;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pen_x_q <= '0;
      pen_y_q <= PEN_Y_RST;
    end else begin
      pen_x_q <= pen_x_d;
      pen_y_q <= pen_y_d;
    end
  end

endmodule

// ----- rtl/gqlay_fifo.sv -----
// Two-entry job queue between the front end and the vertex sequencer.
module gqlay_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  gqlay_pkg::job_t job_i,
  input  logic            pop_i,
  output logic            full_o,
  output logic            valid_o,
  output gqlay_pkg::job_t job_o
);
  import gqlay_pkg::*;

  localparam int DEPTH = 2;
  localparam int PTR_W = $clog2(DEPTH);

  job_t             mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [PTR_W:0]   cnt_q, cnt_d;

  assign full_o  = (cnt_q == (PTR_W+1)'(DEPTH));
  assign valid_o = (cnt_q != '0);
  assign job_o   = mem_q[rd_ptr_q];

  assign wr_ptr_d = push_i ? wr_ptr_q + 1'b1 : wr_ptr_q;
  assign rd_ptr_d = pop_i  ? rd_ptr_q + 1'b1 : rd_ptr_q;
  assign cnt_d    = cnt_q + (PTR_W+1)'(push_i) - (PTR_W+1)'(pop_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= job_i;
    end
  end

endmodule

// ----- rtl/gqlay_back.sv -----
// Vertex sequencer: a job's bars and quad copies, one vertex per cycle unless stalled.
module gqlay_back #(
  parameter int unsigned COORD_FRAC_BITS = 8
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            bold_on_i,
  input  logic            head_valid_i,
  input  gqlay_pkg::job_t head_i,
  output logic            pop_o,
  gqlay_vert_if.source    vert_o
);
  import gqlay_pkg::*;

  localparam logic [1:0] PH_BAR_A = 2'd0;
  localparam logic [1:0] PH_GLYPH = 2'd1;
  localparam logic [1:0] PH_BAR_B = 2'd2;
  localparam logic [1:0] PH_DONE  = 2'd3;

  localparam logic [2:0] VTX_LAST       = 3'd5;
  localparam logic [2:0] COPY_PLAIN     = 3'd0;
  localparam logic [2:0] COPY_LEFT      = 3'd1;
  localparam logic [2:0] COPY_RIGHT     = 3'd2;
  localparam logic [2:0] COPY_UP        = 3'd3;
  localparam logic [2:0] COPY_DOWN      = 3'd4;

  // Per-vertex selects of the two triangles, vertex 0 in bit 0.
  localparam logic [5:0] RIGHT_M = 6'b100011;  // right edge of the glyph quad
  localparam logic [5:0] TOP_M   = 6'b001110;  // top edge of quad, higher-y edge of bar
  localparam logic [5:0] FAR_M   = 6'b011100;  // bar vertices at the pen x

  localparam calc_t ONE    = calc_t'(1) <<< COORD_FRAC_BITS;
  localparam calc_t HALF   = calc_t'(1) <<< (COORD_FRAC_BITS - 1);
  localparam calc_t BAR_LO = -(ONE <<< 1);
  localparam calc_t ZERO   = calc_t'(0);

  logic [1:0] phase_q, phase_d, phase_nxt, phase_start;
  logic [2:0] copy_q, copy_d, vtx_q, vtx_d, copy_last;
  logic       glyph_en_q, glyph_en_d, bar_b_en_q, bar_b_en_d;
  coord_t     bar_a_x_q, bar_a_y_q, bar_b_x_q, bar_b_y_q;
  calc_t      xlb_q, xrb_q, xlt_q, xrt_q, yb_q, yt_q;
  tex_t       umin_q, umax_q, vmin_q, vmax_q;
  calc_t      ld_xb, ld_w, ld_yb, ld_yt;

  logic       out_valid_q, out_valid_d;
  logic       out_kind_q, out_last_q;
  coord_t     out_x_q, out_y_q;
  tex_t       out_u_q, out_v_q;

  logic       out_free, step, vtx_end, phase_end, is_last, load;
  logic       right, top, far;
  calc_t      offx, offy, gsel_x, gsel_y, bar_x, bar_y;
  logic       v_kind;
  coord_t     v_x, v_y;
  tex_t       v_u, v_v;

  assign out_free  = !out_valid_q || vert_o.ready;
  assign step      = (phase_q != PH_DONE) && out_free;
  assign copy_last = bold_on_i ? COPY_DOWN : COPY_PLAIN;
  assign vtx_end   = (vtx_q == VTX_LAST);
  assign phase_end = vtx_end && ((phase_q != PH_GLYPH) || (copy_q == copy_last));

  always_comb begin
    unique case (phase_q)
      PH_BAR_A: phase_nxt = glyph_en_q ? PH_GLYPH : (bar_b_en_q ? PH_BAR_B : PH_DONE);
      PH_GLYPH: phase_nxt = bar_b_en_q ? PH_BAR_B : PH_DONE;
      default:  phase_nxt = PH_DONE;
    endcase
  end

  assign is_last = phase_end && (phase_nxt == PH_DONE);
  assign load    = head_valid_i && ((phase_q == PH_DONE) || (step && is_last));
  assign pop_o   = load;

  assign phase_start = head_i.bar_a_en ? PH_BAR_A : (head_i.glyph_en ? PH_GLYPH : PH_BAR_B);

  // Quad corners of the unshifted copy, built once per job.
  assign ld_xb = calc_t'(head_i.gx) + (calc_t'(head_i.glyph_left) <<< COORD_FRAC_BITS);
  assign ld_w  = calc_t'(head_i.glyph_width) <<< COORD_FRAC_BITS;
  assign ld_yb = calc_t'(head_i.gy) -
                 ((calc_t'(head_i.glyph_top) + calc_t'(head_i.glyph_height)) <<< COORD_FRAC_BITS);
  assign ld_yt = calc_t'(head_i.gy) - (calc_t'(head_i.glyph_top) <<< COORD_FRAC_BITS);

  always_comb begin
    phase_d    = phase_q;
    copy_d     = copy_q;
    vtx_d      = vtx_q;
    glyph_en_d = glyph_en_q;
    bar_b_en_d = bar_b_en_q;
    if (load) begin
      phase_d    = phase_start;
      copy_d     = '0;
      vtx_d      = '0;
      glyph_en_d = head_i.glyph_en;
      bar_b_en_d = head_i.bar_b_en;
    end else if (step) begin
      if (!vtx_end) begin
        vtx_d = vtx_q + 3'd1;
      end else if (phase_end) begin
        vtx_d   = '0;
        copy_d  = '0;
        phase_d = phase_nxt;
      end else begin
        vtx_d  = '0;
        copy_d = copy_q + 3'd1;
      end
    end
  end

  // Vertex of the current slot.
  assign right = RIGHT_M[vtx_q];
  assign top   = TOP_M[vtx_q];
  assign far   = FAR_M[vtx_q];

  always_comb begin
    offx = ZERO;
    offy = ZERO;
    case (copy_q)
      COPY_LEFT:  offx = -HALF;
      COPY_RIGHT: offx = HALF;
      COPY_UP:    offy = -HALF;
      COPY_DOWN:  offy = HALF;
      default: ;
    endcase
  end

  assign gsel_x = top ? (right ? xrt_q : xlt_q) : (right ? xrb_q : xlb_q);
  assign gsel_y = top ? yt_q : yb_q;
  assign bar_x  = (phase_q == PH_BAR_A) ? calc_t'(bar_a_x_q) : calc_t'(bar_b_x_q);
  assign bar_y  = (phase_q == PH_BAR_A) ? calc_t'(bar_a_y_q) : calc_t'(bar_b_y_q);

  always_comb begin
    v_kind = (phase_q != PH_GLYPH);
    if (v_kind) begin
      v_x = far ? sat24(bar_x) : coord_t'(0);
      v_y = sat24(bar_y + (top ? (bold_on_i ? ONE : ZERO) : BAR_LO));
      v_u = '0;
      v_v = '0;
    end else begin
      v_x = sat24(gsel_x + offx);
      v_y = sat24(gsel_y + offy);
      v_u = right ? umax_q : umin_q;
      v_v = top ? vmax_q : vmin_q;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (step) begin
      out_valid_d = 1'b1;
    end else if (vert_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_DONE;
      copy_q      <= '0;
      vtx_q       <= '0;
      glyph_en_q  <= 1'b0;
      bar_b_en_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      copy_q      <= copy_d;
      vtx_q       <= vtx_d;
      glyph_en_q  <= glyph_en_d;
      bar_b_en_q  <= bar_b_en_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      bar_a_x_q <= head_i.bar_a_x;
      bar_a_y_q <= head_i.bar_a_y;
      bar_b_x_q <= head_i.bar_b_x;
      bar_b_y_q <= head_i.bar_b_y;
      xlb_q     <= ld_xb + head_i.shear_bot;
      xrb_q     <= ld_xb + ld_w + head_i.shear_bot;
      xlt_q     <= ld_xb + head_i.shear_top;
      xrt_q     <= ld_xb + ld_w + head_i.shear_top;
      yb_q      <= ld_yb;
      yt_q      <= ld_yt;
      umin_q    <= head_i.tex_u_min;
      umax_q    <= head_i.tex_u_max;
      vmin_q    <= head_i.tex_v_min;
      vmax_q    <= head_i.tex_v_max;
    end
    if (step) begin
      out_kind_q <= v_kind;
      out_x_q    <= v_x;
      out_y_q    <= v_y;
      out_u_q    <= v_u;
      out_v_q    <= v_v;
      out_last_q <= is_last;
    end
  end

  assign vert_o.valid       = out_valid_q;
  assign vert_o.vertex_kind = out_kind_q;
  assign vert_o.pos_x       = out_x_q;
  assign vert_o.pos_y       = out_y_q;
  assign vert_o.tex_u       = out_u_q;
  assign vert_o.tex_v       = out_v_q;
  assign vert_o.last_vertex = out_last_q;

endmodule

// ----- rtl/glyph_quad_layout.sv -----
// Top level of the glyph quad layout block: config registers, front end, job queue, sequencer.
//
//  channel  | dir | handshake       | word carries
//  ---------+-----+-----------------+------------------------------------------------
//  cfg_i    | in  | valid / ready   | index (register 0..3), data (10 bit)
//  char_i   | in  | valid / ready   | one character with glyph metrics and tex box
//  vert_o   | out | valid / ready   | one vertex: kind, pos_x/pos_y Q16.8, tex_u/v, last
//
//  Vertices: the sequencer sends one vertex per cycle while vert_o takes them, so a character
//  gives 6 vertices plain, 30 with bold, plus 6 for each underline bar (newline, end of text).
//  The vertex sequencer is the bottleneck; the front end takes one character per cycle
//  while the two-entry job queue has room. The first vertex of a character passes the queue
//  write, then the sequencer load, then the output register before it is valid on vert_o.
//  Reset: pen at x = 0, y = 32 px, registers at their reset values; no clearing pass.
//  Stalls: vert_o backpressure holds the output register and the sequencer only; the front
//  keeps accepting into the queue. char_i.ready drops only when the queue is full.
//  cfg_i is always ready; the user is to write registers only while the block is idle (not enforced).
module glyph_quad_layout #(
  parameter int unsigned COORD_FRAC_BITS = 8
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  gqlay_cfg_if.sink     cfg_i,
  gqlay_char_if.sink    char_i,
  gqlay_vert_if.source  vert_o
);
  import gqlay_pkg::*;

  cfg_t cfg_q, cfg_d;
  logic fifo_full, fifo_valid, push, pop;
  job_t push_job, head_job;

  // Configuration registers. Writes beyond the list do not exist: the index is 2 bits.
  assign cfg_i.ready = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_i.valid) begin
      unique case (cfg_reg_e'(cfg_i.index))
        REG_BASE_SIZE: cfg_d.base_size    = cfg_i.data;
        REG_BOLD:      cfg_d.bold_on      = cfg_i.data[0];
        REG_ITALIC:    cfg_d.italic_on    = cfg_i.data[0];
        REG_UNDERLINE: cfg_d.underline_on = cfg_i.data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{base_size: BASE_SIZE_RST, bold_on: 1'b0, italic_on: 1'b0,
                 underline_on: 1'b0};
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Front end: pen walk, special characters, shear; one job word per character.
  gqlay_front #(
    .COORD_FRAC_BITS(COORD_FRAC_BITS)
  ) u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_q),
    .char_i (char_i),
    .full_i (fifo_full),
    .push_o (push),
    .job_o  (push_job)
  );

  // Job queue decouples character intake from vertex output.
  gqlay_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (push_job),
    .pop_i   (pop),
    .full_o  (fifo_full),
    .valid_o (fifo_valid),
    .job_o   (head_job)
  );

  // Back end: bars and quad copies, registered vertex output.
  gqlay_back #(
    .COORD_FRAC_BITS(COORD_FRAC_BITS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .bold_on_i    (cfg_q.bold_on),
    .head_valid_i (fifo_valid),
    .head_i       (head_job),
    .pop_o        (pop),
    .vert_o       (vert_o)
  );

endmodule

// ----- rtl/gqlay_checker.sv -----
// Port-level checks of the glyph quad layout vertex stream, bound to the top level.
module gqlay_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic        vertex_kind_i,
  input logic [23:0] pos_x_i,
  input logic [23:0] pos_y_i,
  input logic [15:0] tex_u_i,
  input logic [15:0] tex_v_i,
  input logic        last_vertex_i
);

  // A stalled vertex word holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(pos_x_i) && $stable(pos_y_i) &&
      $stable(tex_u_i) && $stable(tex_v_i) && $stable(vertex_kind_i) &&
      $stable(last_vertex_i))
    else $error("vertex word changed while stalled");

  // Underline vertices carry no texture.
  a_bar_tex: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && vertex_kind_i |-> tex_u_i == 16'd0 && tex_v_i == 16'd0)
    else $error("underline vertex with texture coordinate");

  // Vertices of one character come without gaps once the consumer takes them.
  a_burst: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_ready_i && !last_vertex_i |=> out_valid_i)
    else $error("gap inside the vertex burst of one character");

  // An underline bar closes at the left margin.
  a_bar_close: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && vertex_kind_i && last_vertex_i |-> pos_x_i == 24'd0)
    else $error("closing underline vertex away from x = 0");

endmodule

bind glyph_quad_layout gqlay_checker u_gqlay_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid_i   (vert_o.valid),
  .out_ready_i   (vert_o.ready),
  .vertex_kind_i (vert_o.vertex_kind),
  .pos_x_i       (vert_o.pos_x),
  .pos_y_i       (vert_o.pos_y),
  .tex_u_i       (vert_o.tex_u),
  .tex_v_i       (vert_o.tex_v),
  .last_vertex_i (vert_o.last_vertex)
);
